// ===== rtl/core/lrutrm_pkg.sv =====
package lrutrm_pkg;

    // Fixed field widths of the item channels
    localparam int OP_W     = 3;
    localparam int IN_KEY_W = 16;
    localparam int RN_W     = 4;
    localparam int ACT_W    = 2;
    localparam int OUT_KEY_W = 16;
    localparam int ST_W     = 3;

    // First temporary register number
    localparam logic [RN_W-1:0] TMP_BASE = 4'd8;

    // Actions carried on the result channel
    localparam logic [ACT_W-1:0] ACT_REPLY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd2;

    // Reply status codes
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_NULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_PINNED = 3'd2;
    localparam logic [ST_W-1:0] ST_DOUBLE = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTTMP = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP_LOAD = 3'd0,
        OP_ALLOCATE    = 3'd1,
        OP_RESERVE     = 3'd2,
        OP_FREE        = 3'd3,
        OP_QUERY       = 3'd4,
        OP_SPILL_ALL   = 3'd5,
        OP_CLEAR       = 3'd6,
        OP_STORE       = 3'd7
    } op_t;

    // What the output register is loaded with
    typedef enum logic [3:0] {
        EK_STORE_PTR      = 4'd0,   // store of the pointed slot's key
        EK_LOAD_PTR       = 4'd1,   // load of the item key into the pointed slot
        EK_STORE_ITEM     = 4'd2,   // store of reg_number to the item key
        EK_REPLY_NONE     = 4'd3,   // reply, register 0, key 0
        EK_REPLY_HIT      = 4'd4,   // reply, hit register, item key
        EK_REPLY_PTR_ITEM = 4'd5,   // reply, pointed register, item key
        EK_REPLY_PTR_SLOT = 4'd6,   // reply, pointed register, its key
        EK_REPLY_RN_SLOT  = 4'd7,   // reply, reg_number, pointed slot's key
        EK_REPLY_RN_ZERO  = 4'd8,   // reply, reg_number, key 0
        EK_REPLY_QUERY    = 4'd9,   // reply with presence flag
        EK_REPLY_RN_ITEM  = 4'd10   // reply, reg_number, item key
    } emit_kind_t;

    // Slot pointer updates
    typedef enum logic [2:0] {
        P_HOLD     = 3'd0,
        P_ZERO     = 3'd1,
        P_INC      = 3'd2,
        P_FIRST    = 3'd3,
        P_HIT      = 3'd4,
        P_RN       = 3'd5,
        P_SCAN_END = 3'd6
    } ptr_op_t;

    typedef struct packed {
        logic       load_item;
        ptr_op_t    ptr_op;
        logic       scan_clr;
        logic       scan_en;
        logic       fill;
        logic       pin_set;
        logic       pin_clr;
        logic       clear_all;
        logic       emit;
        emit_kind_t emit_kind;
        logic [ST_W-1:0] emit_status;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic key_null;
        logic hit;
        logic any_free;
        logic any_unpinned;
        logic rn_temp;
        logic ptr_full;
        logic ptr_pinned;
        logic ptr_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/lrutrm_dpath.sv =====
module lrutrm_dpath
    import lrutrm_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16,
    parameter int AGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [23:0] s_tdata,   // var_key[15:0], reg_number[19:16], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_reg[3:0], out_key[19:4], present[20], status[23:21]
    output logic [1:0]  m_tuser,   // action[1:0]
    output logic        m_tlast,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat
);

    localparam int IDX_W = $clog2(SLOTS);

    // Key resizing between the 16-bit ports and the stored width
    function automatic logic [KEY_BITS-1:0] to_key(input logic [IN_KEY_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[KEY_BITS-1:0];
    endfunction

    function automatic logic [OUT_KEY_W-1:0] to_out(input logic [KEY_BITS-1:0] k);
        logic [63:0] w;
        w = 64'(k);
        return w[OUT_KEY_W-1:0];
    endfunction

    // Slot i is register 8+i, wrapped to four bits
    function automatic logic [RN_W-1:0] slot_num(input logic [IDX_W-1:0] i);
        return RN_W'(i) + TMP_BASE;
    endfunction

    // Item registers
    op_t                 op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [RN_W-1:0]     rn_reg;

    // Slot table
    logic [KEY_BITS-1:0] slot_key_reg  [SLOTS];
    logic [KEY_BITS-1:0] slot_key_next [SLOTS];
    logic [AGE_BITS-1:0] slot_age_reg  [SLOTS];
    logic [AGE_BITS-1:0] slot_age_next [SLOTS];
    logic [SLOTS-1:0]    slot_pin_reg, slot_pin_next;

    // Pointer and age scan
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic                best_v_reg, best_v_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]     out_act_reg, out_act_next;
    logic [RN_W-1:0]      out_num_reg, out_num_next;
    logic [OUT_KEY_W-1:0] out_key_reg, out_key_next;
    logic                 out_pres_reg, out_pres_next;
    logic [ST_W-1:0]      out_st_reg, out_st_next;
    logic                 out_last_reg, out_last_next;

    logic                 hit, any_free, any_unp;
    logic [IDX_W-1:0]     hit_idx, free_idx, rn_idx;
    logic                 rn_temp, take;
    logic [KEY_BITS-1:0]  ptr_key;
    logic                 out_free;

    assign ptr_key  = slot_key_reg[ptr_reg];
    assign rn_idx   = IDX_W'(rn_reg[2:0]);
    assign rn_temp  = rn_reg[3] && (32'(rn_reg[2:0]) < SLOTS);
    assign out_free = !out_valid_reg || m_tready;

    // Parallel key compare and priority pick, lowest slot wins
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        any_free = 1'b0;
        free_idx = '0;
        any_unp  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_key_reg[i] == key_reg) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!slot_pin_reg[i] && slot_key_reg[i] == '0) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (!slot_pin_reg[i]) begin
                any_unp = 1'b1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        stat.op           = op_reg;
        stat.key_null     = (key_reg == '0);
        stat.hit          = hit;
        stat.any_free     = any_free;
        stat.any_unpinned = any_unp;
        stat.rn_temp      = rn_temp;
        stat.ptr_full     = (ptr_key != '0);
        stat.ptr_pinned   = slot_pin_reg[ptr_reg];
        stat.ptr_last     = (ptr_reg == IDX_W'(SLOTS - 1));
        stat.out_free     = out_free;
    end

    // Oldest-unpinned scan, one slot a cycle; strict compare keeps the lowest on ties
    assign take = !slot_pin_reg[ptr_reg] &&
                  (!best_v_reg || slot_age_reg[ptr_reg] > best_age_reg);

    always_comb begin
        best_next     = best_reg;
        best_age_next = best_age_reg;
        best_v_next   = best_v_reg;
        if (cmd.scan_clr) begin
            best_v_next = 1'b0;
        end
        if (cmd.scan_en && take) begin
            best_next     = ptr_reg;
            best_age_next = slot_age_reg[ptr_reg];
            best_v_next   = 1'b1;
        end
    end

    // Pointer
    always_comb begin
        case (cmd.ptr_op)
            P_HOLD:     ptr_next = ptr_reg;
            P_ZERO:     ptr_next = '0;
            P_INC:      ptr_next = ptr_reg + 1'b1;
            P_FIRST:    ptr_next = free_idx;
            P_HIT:      ptr_next = hit_idx;
            P_RN:       ptr_next = rn_idx;
            P_SCAN_END: ptr_next = take ? ptr_reg : best_reg;
            default:    ptr_next = ptr_reg;
        endcase
    end

    // Slot table updates: clear, fill with ageing, pin changes
    always_comb begin
        slot_pin_next = slot_pin_reg;
        for (int i = 0; i < SLOTS; i++) begin
            slot_key_next[i] = slot_key_reg[i];
            slot_age_next[i] = slot_age_reg[i];
            if (cmd.clear_all) begin
                slot_key_next[i] = '0;
                slot_age_next[i] = '0;
            end
            if (cmd.fill) begin
                if (IDX_W'(i) == ptr_reg) begin
                    slot_key_next[i] = key_reg;
                    slot_age_next[i] = '0;
                end else if (slot_age_reg[i] != '1) begin
                    slot_age_next[i] = slot_age_reg[i] + 1'b1;
                end
            end
            if (IDX_W'(i) == ptr_reg) begin
                if (cmd.pin_set) begin
                    slot_pin_next[i] = 1'b1;
                end
                if (cmd.pin_clr) begin
                    slot_pin_next[i] = 1'b0;
                end
            end
        end
    end

    // Result item formation
    always_comb begin
        out_act_next  = out_act_reg;
        out_num_next  = out_num_reg;
        out_key_next  = out_key_reg;
        out_pres_next = out_pres_reg;
        out_st_next   = out_st_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_act_next   = ACT_REPLY;
            out_num_next   = '0;
            out_key_next   = '0;
            out_pres_next  = 1'b0;
            out_st_next    = cmd.emit_status;
            out_last_next  = 1'b1;
            case (cmd.emit_kind)
                EK_STORE_PTR: begin
                    out_act_next  = ACT_STORE;
                    out_num_next  = slot_num(ptr_reg);
                    out_key_next  = to_out(ptr_key);
                    out_last_next = 1'b0;
                end
                EK_LOAD_PTR: begin
                    out_act_next  = ACT_LOAD;
                    out_num_next  = slot_num(ptr_reg);
                    out_key_next  = to_out(key_reg);
                    out_last_next = 1'b0;
                end
                EK_STORE_ITEM: begin
                    out_act_next  = ACT_STORE;
                    out_num_next  = rn_reg;
                    out_key_next  = to_out(key_reg);
                    out_last_next = 1'b0;
                end
                EK_REPLY_NONE: begin
                end
                EK_REPLY_HIT: begin
                    out_num_next = slot_num(hit_idx);
                    out_key_next = to_out(key_reg);
                end
                EK_REPLY_PTR_ITEM: begin
                    out_num_next = slot_num(ptr_reg);
                    out_key_next = to_out(key_reg);
                end
                EK_REPLY_PTR_SLOT: begin
                    out_num_next = slot_num(ptr_reg);
                    out_key_next = to_out(ptr_key);
                end
                EK_REPLY_RN_SLOT: begin
                    out_num_next = rn_reg;
                    out_key_next = to_out(ptr_key);
                end
                EK_REPLY_RN_ZERO: begin
                    out_num_next = rn_reg;
                end
                EK_REPLY_QUERY: begin
                    out_num_next  = hit ? slot_num(hit_idx) : '0;
                    out_key_next  = to_out(key_reg);
                    out_pres_next = hit;
                end
                EK_REPLY_RN_ITEM: begin
                    out_num_next = rn_reg;
                    out_key_next = to_out(key_reg);
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_key_reg[i] <= '0;
                slot_age_reg[i] <= '0;
            end
            slot_pin_reg  <= '0;
            ptr_reg       <= '0;
            best_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_key_reg[i] <= slot_key_next[i];
                slot_age_reg[i] <= slot_age_next[i];
            end
            slot_pin_reg  <= slot_pin_next;
            ptr_reg       <= ptr_next;
            best_v_reg    <= best_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= op_t'(s_tuser);
            key_reg <= to_key(s_tdata[15:0]);
            rn_reg  <= s_tdata[19:16];
        end
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        out_act_reg  <= out_act_next;
        out_num_reg  <= out_num_next;
        out_key_reg  <= out_key_next;
        out_pres_reg <= out_pres_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_st_reg, out_pres_reg, out_key_reg, out_num_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/lrutrm_ctrl.sv =====
module lrutrm_ctrl
    import lrutrm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_VICTIM,
        S_LOAD,
        S_FREE,
        S_SPILL,
        S_STORE,
        S_REPLY
    } state_t;

    state_t          state_reg, state_next;
    emit_kind_t      rkind_reg, rkind_next;
    logic [ST_W-1:0] rst_reg, rst_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        logic            rep_go;
        emit_kind_t      rep_kind;
        logic [ST_W-1:0] rep_st;
        logic            victim;
        logic            needs_key;

        state_next = state_reg;
        rkind_next = rkind_reg;
        rst_next   = rst_reg;
        cmd        = '0;
        cmd.ptr_op = P_HOLD;
        cmd.emit_kind = EK_REPLY_NONE;
        cmd.emit_status = ST_OK;
        rep_go     = 1'b0;
        rep_kind   = EK_REPLY_NONE;
        rep_st     = ST_OK;
        victim     = 1'b0;
        needs_key  = (stat.op == OP_LOOKUP_LOAD) || (stat.op == OP_ALLOCATE) ||
                     (stat.op == OP_QUERY) || (stat.op == OP_STORE);

        case (state_reg)
            S_IDLE: begin
                cmd.load_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECIDE;
                end
            end

            // Classify the item; plain replies leave at once when the output is free
            S_DECIDE: begin
                if (needs_key && stat.key_null) begin
                    rep_go = 1'b1;
                    rep_st = ST_NULL;
                end else begin
                    case (stat.op)
                        OP_LOOKUP_LOAD: begin
                            if (stat.hit) begin
                                rep_go   = 1'b1;
                                rep_kind = EK_REPLY_HIT;
                            end else begin
                                victim = 1'b1;
                            end
                        end
                        OP_ALLOCATE: begin
                            if (stat.hit) begin
                                cmd.ptr_op = P_HIT;
                                state_next = S_VICTIM;
                            end else begin
                                victim = 1'b1;
                            end
                        end
                        OP_RESERVE: victim = 1'b1;
                        OP_FREE: begin
                            if (!stat.rn_temp) begin
                                rep_go   = 1'b1;
                                rep_kind = EK_REPLY_RN_ZERO;
                                rep_st   = ST_NOTTMP;
                            end else begin
                                cmd.ptr_op = P_RN;
                                state_next = S_FREE;
                            end
                        end
                        OP_QUERY: begin
                            rep_go   = 1'b1;
                            rep_kind = EK_REPLY_QUERY;
                        end
                        OP_SPILL_ALL: begin
                            cmd.ptr_op = P_ZERO;
                            state_next = S_SPILL;
                        end
                        OP_CLEAR: begin
                            cmd.clear_all = 1'b1;
                            rep_go = 1'b1;
                        end
                        OP_STORE: state_next = S_STORE;
                        default: begin
                        end
                    endcase
                end

                // Victim choice: empty unpinned slot first, else age scan
                if (victim) begin
                    if (!stat.any_unpinned) begin
                        rep_go = 1'b1;
                        rep_st = ST_PINNED;
                    end else if (stat.any_free) begin
                        cmd.ptr_op = P_FIRST;
                        state_next = S_VICTIM;
                    end else begin
                        cmd.ptr_op   = P_ZERO;
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                end

                if (rep_go) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = rep_kind;
                        cmd.emit_status = rep_st;
                        state_next      = S_IDLE;
                    end else begin
                        rkind_next = rep_kind;
                        rst_next   = rep_st;
                        state_next = S_REPLY;
                    end
                end
            end

            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.ptr_last) begin
                    cmd.ptr_op = P_SCAN_END;
                    state_next = S_VICTIM;
                end else begin
                    cmd.ptr_op = P_INC;
                end
            end

            // Pointer holds the victim
            S_VICTIM: begin
                if (stat.op == OP_RESERVE) begin
                    cmd.pin_set = 1'b1;
                    rkind_next  = EK_REPLY_PTR_SLOT;
                    rst_next    = ST_OK;
                    state_next  = S_REPLY;
                end else if (!stat.ptr_full || stat.out_free) begin
                    // old key leaves the slot in the same cycle as the refill
                    cmd.emit      = stat.ptr_full;
                    cmd.emit_kind = EK_STORE_PTR;
                    cmd.fill      = 1'b1;
                    if (stat.op == OP_LOOKUP_LOAD) begin
                        state_next = S_LOAD;
                    end else begin
                        rkind_next = EK_REPLY_PTR_ITEM;
                        rst_next   = ST_OK;
                        state_next = S_REPLY;
                    end
                end
            end

            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_LOAD_PTR;
                    rkind_next    = EK_REPLY_PTR_ITEM;
                    rst_next      = ST_OK;
                    state_next    = S_REPLY;
                end
            end

            S_FREE: begin
                rkind_next = EK_REPLY_RN_SLOT;
                if (stat.ptr_pinned) begin
                    cmd.pin_clr = 1'b1;
                    rst_next    = ST_OK;
                end else begin
                    rst_next    = ST_DOUBLE;
                end
                state_next = S_REPLY;
            end

            // One slot a cycle unless a store waits for the output; stores for occupied slots only
            S_SPILL: begin
                if (!stat.ptr_full || stat.out_free) begin
                    cmd.emit      = stat.ptr_full;
                    cmd.emit_kind = EK_STORE_PTR;
                    if (stat.ptr_last) begin
                        rkind_next = EK_REPLY_NONE;
                        rst_next   = ST_OK;
                        state_next = S_REPLY;
                    end else begin
                        cmd.ptr_op = P_INC;
                    end
                end
            end

            S_STORE: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_STORE_ITEM;
                    rkind_next    = EK_REPLY_RN_ITEM;
                    rst_next      = ST_OK;
                    state_next    = S_REPLY;
                end
            end

            S_REPLY: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = rkind_reg;
                    cmd.emit_status = rst_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rkind_reg <= EK_REPLY_NONE;
            rst_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            rkind_reg <= rkind_next;
            rst_reg   <= rst_next;
        end
    end

endmodule

// ===== rtl/core/lru_temp_register_map.sv =====
// Channel  | Direction | Ports                          | Item contents
// ---------+-----------+--------------------------------+-------------------------------------
// s_       | in        | s_tvalid s_tready s_tdata      | tuser: opcode; tdata: var_key,
//          |           | s_tuser                        | reg_number
// m_       | out       | m_tvalid m_tready m_tdata      | tuser: action; tdata: out_reg,
//          |           | m_tuser m_tlast                | out_key, present, status; tlast: last
//
// One item at a time. A plain reply is accepted, then decided and emitted when the output is free.
// A miss with an empty unpinned slot goes to that slot at once; with none, the age scan
// first walks the slots, one slot a cycle through the single slot pointer.
// Spill all walks every slot in turn. Output stalls hold every step that emits an item.
// Reset (aresetn low, synchronous) empties every slot, zeroes ages and pins at once.
// The output register lets a new item be accepted while the last reply still waits.
module lru_temp_register_map
    import lrutrm_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16,
    parameter int AGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // var_key[15:0], reg_number[19:16], zero pad [23:20]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_reg[3:0], out_key[19:4], present[20], status[23:21]
    output logic [1:0]  m_tuser,   // action[1:0]
    output logic        m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    lrutrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Slot table, scan and output register
    lrutrm_dpath #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .AGE_BITS (AGE_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== rtl/core/lrutrm_sva.sv =====
module lrutrm_sva
    import lrutrm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result item changed while stalled");

    // Only the reply closes an item's results
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == ACT_REPLY)))
        else $error("tlast does not match reply action");

    // Store and load items carry no status and no presence flag
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[23:20] == 4'd0))
        else $error("status or present set on a non-reply item");

    // One item in work at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

endmodule

bind lru_temp_register_map lrutrm_sva u_lrutrm_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/lrutrm_checker.sv =====
// Watches both item channels of lru_temp_register_map and keeps its own copy of
// the slot table. Every accepted input is applied to that copy; the actions it
// should cause are queued and matched in order against the result channel.
module lrutrm_checker
    import lrutrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // var_key[15:0], reg_number[19:16], zero pad [23:20]
    input  logic [2:0]  s_tuser,    // opcode[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // out_reg[3:0], out_key[19:4], present[20], status[23:21]
    input  logic [1:0]  m_tuser,    // action[1:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_SLOTS = 8;
    localparam logic [15:0] AGE_SAT = 16'hFFFF;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [3:0]       out_reg;
        logic [15:0]      out_key;
        logic             present;
        logic [ST_W-1:0]  status;
        logic             last;
    } map_item_t;

    // Shadow slot table
    logic [15:0] map_key [MAP_SLOTS];
    logic [15:0] map_age [MAP_SLOTS];
    logic        map_pin [MAP_SLOTS];

    // Actions still owed by the block, oldest first
    map_item_t due_items[$];

    initial fail_count = 0;

    function automatic logic [3:0] slot_reg(int i);
        return TMP_BASE + 4'(i);
    endfunction

    function automatic int find_slot(logic [15:0] k);
        for (int i = 0; i < MAP_SLOTS; i++)
            if (map_key[i] == k) return i;
        return -1;
    endfunction

    // First empty unpinned slot, else the oldest unpinned one (lowest on a tie)
    function automatic int choose_victim();
        int          best;
        logic [15:0] best_age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < MAP_SLOTS; i++) begin
            if (map_pin[i]) continue;
            if (map_key[i] == '0) return i;
            if (best < 0 || map_age[i] > best_age) begin
                best = i;
                best_age = map_age[i];
            end
        end
        return best;
    endfunction

    task automatic emit_item(logic [ACT_W-1:0] act, logic [3:0] rg, logic [15:0] k,
                             logic pres, logic [ST_W-1:0] st);
        map_item_t it;
        it.action  = act;
        it.out_reg = rg;
        it.out_key = k;
        it.present = pres;
        it.status  = st;
        it.last    = (act == ACT_REPLY);   // the reply always closes the item
        due_items.push_back(it);
    endtask

    // Old key goes out first; the refilled slot is youngest, others age
    task automatic refill_slot(int v, logic [15:0] k);
        if (map_key[v] != '0)
            emit_item(ACT_STORE, slot_reg(v), map_key[v], 1'b0, ST_OK);
        for (int i = 0; i < MAP_SLOTS; i++) begin
            if (i == v) begin
                map_age[i] = '0;
                map_key[i] = k;
            end else if (map_age[i] < AGE_SAT) begin
                map_age[i] = map_age[i] + 16'd1;
            end
        end
    endtask

    task automatic apply_opcode(op_t op, logic [15:0] k, logic [3:0] rn);
        int   s;
        logic needs_key;
        needs_key = op inside {OP_LOOKUP_LOAD, OP_ALLOCATE, OP_QUERY, OP_STORE};
        if (needs_key && k == '0) begin
            emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_NULL);
            return;
        end
        case (op)
            OP_LOOKUP_LOAD: begin
                s = find_slot(k);
                if (s >= 0) begin
                    emit_item(ACT_REPLY, slot_reg(s), k, 1'b0, ST_OK);
                end else begin
                    s = choose_victim();
                    if (s < 0) begin
                        emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_PINNED);
                    end else begin
                        refill_slot(s, k);
                        emit_item(ACT_LOAD, slot_reg(s), k, 1'b0, ST_OK);
                        emit_item(ACT_REPLY, slot_reg(s), k, 1'b0, ST_OK);
                    end
                end
            end
            OP_ALLOCATE: begin
                s = find_slot(k);
                if (s < 0) s = choose_victim();
                if (s < 0) begin
                    emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_PINNED);
                end else begin
                    refill_slot(s, k);
                    emit_item(ACT_REPLY, slot_reg(s), k, 1'b0, ST_OK);
                end
            end
            OP_RESERVE: begin
                s = choose_victim();
                if (s < 0) begin
                    emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_PINNED);
                end else begin
                    map_pin[s] = 1'b1;
                    emit_item(ACT_REPLY, slot_reg(s), map_key[s], 1'b0, ST_OK);
                end
            end
            OP_FREE: begin
                if (int'(rn) < int'(TMP_BASE) || int'(rn) >= int'(TMP_BASE) + MAP_SLOTS) begin
                    emit_item(ACT_REPLY, rn, 16'd0, 1'b0, ST_NOTTMP);
                end else begin
                    s = int'(rn) - int'(TMP_BASE);
                    if (!map_pin[s]) begin
                        emit_item(ACT_REPLY, rn, map_key[s], 1'b0, ST_DOUBLE);
                    end else begin
                        map_pin[s] = 1'b0;
                        emit_item(ACT_REPLY, rn, map_key[s], 1'b0, ST_OK);
                    end
                end
            end
            OP_QUERY: begin
                s = find_slot(k);
                emit_item(ACT_REPLY, (s >= 0) ? slot_reg(s) : 4'd0, k, s >= 0, ST_OK);
            end
            OP_SPILL_ALL: begin
                for (int i = 0; i < MAP_SLOTS; i++)
                    if (map_key[i] != '0)
                        emit_item(ACT_STORE, slot_reg(i), map_key[i], 1'b0, ST_OK);
                emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_OK);
            end
            OP_CLEAR: begin
                // pins survive a clear
                for (int i = 0; i < MAP_SLOTS; i++) begin
                    map_key[i] = '0;
                    map_age[i] = '0;
                end
                emit_item(ACT_REPLY, 4'd0, 16'd0, 1'b0, ST_OK);
            end
            default: begin
                emit_item(ACT_STORE, rn, k, 1'b0, ST_OK);
                emit_item(ACT_REPLY, rn, k, 1'b0, ST_OK);
            end
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Apply inputs and match results on each clock edge
    always @(posedge aclk) begin
        map_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAP_SLOTS; i++) begin
                map_key[i] = '0;
                map_age[i] = '0;
                map_pin[i] = 1'b0;
            end
            due_items.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_opcode(op_t'(s_tuser), s_tdata[15:0], s_tdata[19:16]);
            if (m_tvalid && m_tready) begin
                if (due_items.size() == 0) begin
                    $error("result item with nothing due: action %0d tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = due_items.pop_front();
                    check_field("action",  want.action,  m_tuser);
                    check_field("out_reg", want.out_reg, m_tdata[3:0]);
                    check_field("out_key", want.out_key, m_tdata[19:4]);
                    check_field("present", want.present, m_tdata[20]);
                    check_field("status",  want.status,  m_tdata[23:21]);
                    check_field("last",    want.last,    m_tlast);
                end
            end
        end
        pending = due_items.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import lrutrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE = 12;
    localparam int PHASE_ITEMS = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // var_key[15:0], reg_number[19:16], zero pad [23:20]
    logic [2:0]  s_tuser;    // opcode[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // out_reg[3:0], out_key[19:4], present[20], status[23:21]
    logic [1:0]  m_tuser;    // action[1:0]
    logic        m_tlast;

    int fail_count;
    int pending;
    int src_idle_pct;
    int snk_stall_pct;
    int idle_cycles;
    logic [15:0] key_pool [POOL_SIZE];

    lru_temp_register_map dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lrutrm_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: ends the run if nothing moves for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) break;
        end
        $display("lru_temp_register_map test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(op_t op, logic [15:0] k, logic [3:0] rn);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, rn, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly keys from a small pool so hits and evictions happen
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 16'h0000;
        if (r < 20) return 16'($urandom_range(65535));
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic op_t pick_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 30) return OP_LOOKUP_LOAD;
        if (r < 45) return OP_ALLOCATE;
        if (r < 53) return OP_RESERVE;
        if (r < 66) return OP_FREE;
        if (r < 78) return OP_QUERY;
        if (r < 83) return OP_SPILL_ALL;
        if (r < 87) return OP_CLEAR;
        return OP_STORE;
    endfunction

    // Stimulus and verdict
    initial begin
        op_t         op;
        logic [3:0]  rn;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        key_pool[0] = 16'hFFFF;
        key_pool[1] = 16'h0001;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(1, 65535));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // null key on every opcode that needs one
        send_item(OP_LOOKUP_LOAD, 16'h0000, 4'd0);
        send_item(OP_ALLOCATE,    16'h0000, 4'd0);
        send_item(OP_QUERY,       16'h0000, 4'd0);
        send_item(OP_STORE,       16'h0000, 4'd15);
        // miss into an empty slot, hit, another miss
        send_item(OP_LOOKUP_LOAD, 16'hFFFF, 4'd15);
        send_item(OP_LOOKUP_LOAD, 16'hFFFF, 4'd0);
        send_item(OP_LOOKUP_LOAD, 16'h0001, 4'd0);
        // allocate of a held key refills its own slot; a new key takes an empty one
        send_item(OP_ALLOCATE,    16'h0001, 4'd0);
        send_item(OP_ALLOCATE,    16'h8000, 4'd0);
        send_item(OP_QUERY,       16'hFFFF, 4'd0);
        send_item(OP_STORE,       16'hA5A5, 4'd0);
        // free outside the temporaries, then of an unpinned slot
        send_item(OP_FREE,        16'h0000, 4'd0);
        send_item(OP_FREE,        16'h0000, 4'd8);
        // pin every slot; anything wanting a victim is then refused
        for (int i = 0; i < 9; i++) send_item(OP_RESERVE, 16'h7FFF, 4'd0);
        send_item(OP_LOOKUP_LOAD, 16'h4242, 4'd0);
        send_item(OP_ALLOCATE,    16'h4242, 4'd0);
        send_item(OP_LOOKUP_LOAD, 16'hFFFF, 4'd0);
        // unpin the top slot, then free it again
        send_item(OP_FREE,        16'h0000, 4'd15);
        send_item(OP_FREE,        16'h0000, 4'd15);
        send_item(OP_SPILL_ALL,   16'h0000, 4'd0);
        send_item(OP_CLEAR,       16'h0000, 4'd0);

        // random items, one phase per idling pattern
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                default: begin src_idle_pct = 30; snk_stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = pick_opcode();
                if (op == OP_FREE && $urandom_range(99) < 85)
                    rn = TMP_BASE + 4'($urandom_range(7));
                else
                    rn = 4'($urandom_range(15));
                send_item(op, pick_key(), rn);
            end
        end
        s_tvalid <= 1'b0;
        snk_stall_pct = 0;

        // drain, then allow for anything late or spurious
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("lru_temp_register_map test passed");
        else
            $display("lru_temp_register_map test failed");
        $finish;
    end

endmodule
